// ===== hdl/fdct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdct_pkg
// shared types, constants and arithmetic helpers for the 8x8 fast fdct
// ----------------------------------------------------------------------------
package fdct_pkg;

  localparam int BLOCK_SIDE_DEF = 8;
  localparam int DATA_W         = 16;
  localparam int FRAC_BITS      = 8;
  localparam int K_W            = 10;

  localparam logic signed [K_W-1:0] K_0_382 = 10'sd98;
  localparam logic signed [K_W-1:0] K_0_541 = 10'sd139;
  localparam logic signed [K_W-1:0] K_0_707 = 10'sd181;
  localparam logic signed [K_W-1:0] K_1_306 = 10'sd334;

  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_CALC,
    ST_WRITE,
    ST_OUT
  } state_t;

  // signed product by constant, arithmetic shift by fraction bits, low 16 bits
  function automatic word_t mulk(input word_t x, input logic signed [K_W-1:0] k);
    logic signed [DATA_W+K_W-1:0] p;
    logic signed [DATA_W+K_W-1:0] s;
    begin
      p = $signed(x) * k;
      s = p >>> FRAC_BITS;
      mulk = s[DATA_W-1:0];
    end
  endfunction

endpackage : fdct_pkg
`default_nettype wire

// ===== hdl/fast_integer_fdct_8x8.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fast_integer_fdct_8x8
// 8x8 aan forward dct over a block memory, unscaled 16-bit output
// ----------------------------------------------------------------------------
// load: one sample per cycle while busy is low, 64 transactions per block
// transform: 16 passes (8 rows then 8 columns); each reads 8 elements, loads the
//   butterfly register, then writes 8 results, one access at a time on the single port
// output: 64 coefficients on consecutive cycles, one read per cycle
// the receiver cannot stall
// synchronous active-low reset clears the sequencer and counters only
module fast_integer_fdct_8x8 #(
  parameter int BLOCK_SIDE = fdct_pkg::BLOCK_SIDE_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire fdct_pkg::word_t      in_sample,
  output logic                      out_valid,
  output fdct_pkg::word_t           out_coefficient,
  output logic                      out_last
);
  import fdct_pkg::*;

  localparam int SZ  = BLOCK_SIDE * BLOCK_SIDE;
  localparam int AW  = $clog2(SZ);
  localparam int SW  = $clog2(BLOCK_SIDE);

  // block memory, one port, registered read
  word_t mem [SZ];
  logic [AW-1:0] addr;
  logic          we;
  word_t         wdata, rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;       // load / output index
  logic [SW:0]   pass_r, pass_nxt;     // 0..15: rows then columns
  logic [SW:0]   el_r, el_nxt;         // element in the pass, one beyond for latency
  logic          ov_r, ov_nxt;
  logic [AW-1:0] oa_r;                 // address being shown (for last flag)
  word_t vin_r [BLOCK_SIDE];
  word_t vout [8];
  word_t vin8 [8];

  always_comb begin
    for (int i = 0; i < 8; i++) vin8[i] = vin_r[i];
  end

  fdct_even u_bfly (.clk(clk), .v_i(vin8), .v_o(vout));

  // address of element e in the current pass
  function automatic logic [AW-1:0] pass_addr(input logic [SW:0] p, input logic [SW-1:0] e);
    logic [SW-1:0] line;
    begin
      line = p[SW-1:0];
      if (p[SW]) pass_addr = {e, line};
      else       pass_addr = {line, e};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      pass_r  <= '0;
      el_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pass_r  <= pass_nxt;
      el_r    <= el_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // capture read data of the pass
  always_ff @(posedge clk) begin
    if (state_r == ST_READ && el_r != '0) begin
      vin_r[el_r[SW-1:0] - 1'b1] <= rdata_r;
    end
    if (state_r == ST_CALC) begin
      vin_r[BLOCK_SIDE-1] <= rdata_r;
    end
    oa_r <= cnt_r;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pass_nxt  = pass_r;
    el_nxt    = el_r;
    ov_nxt    = 1'b0;
    busy      = 1'b1;
    we        = 1'b0;
    addr      = cnt_r;
    wdata     = in_sample;
    unique case (state_r)
      ST_LOAD: begin
        busy = 1'b0;
        we   = start;
        if (start) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == AW'(SZ - 1)) begin
            state_nxt = ST_READ;
            pass_nxt  = '0;
            el_nxt    = '0;
          end
        end
      end
      ST_READ: begin
        addr   = pass_addr(pass_r, el_r[SW-1:0]);
        el_nxt = el_r + 1'b1;
        if (el_r == (SW+1)'(BLOCK_SIDE - 1)) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        // last element of the pass lands in the input vector this cycle
        el_nxt    = '0;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        // el 0: butterfly register stage loads; el 1..8 write its stable output
        if (el_r != '0) begin
          we    = 1'b1;
          addr  = pass_addr(pass_r, el_r[SW-1:0] - 1'b1);
          wdata = vout[el_r[SW-1:0] - 1'b1];
        end
        el_nxt = el_r + 1'b1;
        if (el_r == (SW+1)'(BLOCK_SIDE)) begin
          el_nxt = '0;
          if (pass_r == (SW+1)'(2*BLOCK_SIDE - 1)) begin
            state_nxt = ST_OUT;
            cnt_nxt   = '0;
          end else begin
            pass_nxt  = pass_r + 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      ST_OUT: begin
        addr    = cnt_r;
        ov_nxt  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == AW'(SZ - 1)) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  assign out_valid       = ov_r;
  assign out_coefficient = rdata_r;
  assign out_last        = ov_r && (oa_r == AW'(SZ - 1));

  // results only appear after the output sweep starts
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ST_OUT)
    else $error("coefficient outside output sweep");
  // no memory write during output
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |-> !we)
    else $error("write during output sweep");
  // last marks the end of the sweep, then loading resumes
  assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> state_r == ST_LOAD)
    else $error("last without return to load");

endmodule : fast_integer_fdct_8x8
`default_nettype wire

// ===== hdl/fdct_even.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdct_even
// registered 1-d aan butterfly, even and odd parts in two stages
// ----------------------------------------------------------------------------
module fdct_even (
  input  wire logic                 clk,
  input  wire fdct_pkg::word_t      v_i [8],
  output fdct_pkg::word_t           v_o [8]
);
  import fdct_pkg::*;

  word_t t0, t1, t2, t3, t4, t5, t6, t7;
  word_t e10, e11, e12, e13, o10, o11, o12;
  word_t e10_r, e11_r, e13_r, t7_r;
  word_t z1_r, z5_r, m541_r, m1306_r, z3_r;
  word_t z2, z4, z11, z13, z1d;

  always_comb begin
    t0 = v_i[0] + v_i[7]; t7 = v_i[0] - v_i[7];
    t1 = v_i[1] + v_i[6]; t6 = v_i[1] - v_i[6];
    t2 = v_i[2] + v_i[5]; t5 = v_i[2] - v_i[5];
    t3 = v_i[3] + v_i[4]; t4 = v_i[3] - v_i[4];
    e10 = t0 + t3; e13 = t0 - t3;
    e11 = t1 + t2; e12 = t1 - t2;
    o10 = t4 + t5; o11 = t5 + t6; o12 = t6 + t7;
  end

  // multiplies registered before the final adds
  always_ff @(posedge clk) begin
    e10_r   <= e10;
    e11_r   <= e11;
    e13_r   <= e13;
    t7_r    <= t7;
    z1_r    <= mulk(e12 + e13, K_0_707);
    z5_r    <= mulk(o10 - o12, K_0_382);
    m541_r  <= mulk(o10, K_0_541);
    m1306_r <= mulk(o12, K_1_306);
    z3_r    <= mulk(o11, K_0_707);
  end

  always_comb begin
    z1d = z1_r;
    z2  = m541_r + z5_r;
    z4  = m1306_r + z5_r;
    z11 = t7_r + z3_r;
    z13 = t7_r - z3_r;
    v_o[0] = e10_r + e11_r;
    v_o[4] = e10_r - e11_r;
    v_o[2] = e13_r + z1d;
    v_o[6] = e13_r - z1d;
    v_o[5] = z13 + z2;
    v_o[3] = z13 - z2;
    v_o[1] = z11 + z4;
    v_o[7] = z11 - z4;
  end

endmodule : fdct_even
`default_nettype wire
